### src/p2c_pkg.sv
// Shared widths, arctangent table and helper functions for the polar-to-Cartesian converter.
package p2c_pkg;

	localparam int ANGLE_W = 32;
	localparam int COORD_W = 32;
	localparam int Z_W = ANGLE_W + 2;
	localparam int PROD1_W = COORD_W + 2;
	localparam int PROD2_W = PROD1_W + 2;
	localparam int ATAN_N = 32;

	// atan(2^-i) as a fraction of a full turn, scaled by 2^32
	localparam logic [ANGLE_W-1:0] ATAN_TURNS [ATAN_N] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	// integer square root, elaboration only
	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] bitv;
		rem = v;
		res = '0;
		bitv = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (bitv > v) begin
				bitv = bitv >> 2;
			end
		end
		for (int i = 0; i < 32; i++) begin
			if (bitv != '0) begin
				if (rem >= res + bitv) begin
					rem = rem - (res + bitv);
					res = (res >> 1) + bitv;
				end else begin
					res = res >> 1;
				end
				bitv = bitv >> 2;
			end
		end
		return res;
	endfunction

	// gain-compensated start value floor(2^frac * 2^30 / sqrt(P)), elaboration only
	function automatic logic [63:0] cordic_gain_start(input int stages, input int frac_bits);
		logic [63:0] p;
		logic [63:0] g;
		logic [63:0] rem;
		logic [63:0] q;
		p = 64'd1 << 60;
		for (int i = 0; i < ATAN_N; i++) begin
			if (i < stages) begin
				p = p + (p >> (2 * i));
			end
		end
		g = isqrt64(p);
		rem = 64'd1 << 30;
		q = '0;
		for (int i = 0; i < 64; i++) begin
			if (i < frac_bits) begin
				rem = rem << 1;
				q = q << 1;
				if (rem >= g) begin
					rem = rem - g;
					q[0] = 1'b1;
				end
			end
		end
		return q;
	endfunction

	// clamp to the signed coordinate range
	function automatic logic [COORD_W-1:0] sat_coord(input logic signed [PROD2_W-1:0] v);
		logic [PROD2_W-COORD_W:0] upper;
		upper = v[PROD2_W-1:COORD_W-1];
		priority if (upper == '0 || upper == '1) begin
			return v[COORD_W-1:0];
		end else if (v[PROD2_W-1]) begin
			return {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			return {1'b0, {(COORD_W-1){1'b1}}};
		end
	endfunction

endpackage

### src/p2c_cordic.sv
// Two-lane pipelined rotation CORDIC producing cosine and sine of two binary angles.
module p2c_cordic #(
	parameter int CORDIC_STAGES = 24,
	parameter int DATA_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                item_valid,
	input  logic signed [p2c_pkg::COORD_W-1:0] radius,
	input  logic [p2c_pkg::ANGLE_W-1:0]        angle [2],
	output logic                                res_valid,
	output logic signed [p2c_pkg::COORD_W-1:0] radius_dly,
	output logic signed [DATA_WIDTH:0]          cosine [2],
	output logic signed [DATA_WIDTH:0]          sine [2]
);
	import p2c_pkg::*;

	localparam int CW = DATA_WIDTH + 1;
	localparam int F = DATA_WIDTH - 2;
	localparam int N = CORDIC_STAGES;
	localparam logic [63:0] K_FULL = cordic_gain_start(CORDIC_STAGES, F);
	localparam logic signed [CW-1:0] K_START = signed'(K_FULL[CW-1:0]);

	// index 0: folded input, 1..N: rotations, N+1: sign restored
	logic signed [CW-1:0]      x_s [N+2][2];
	logic signed [CW-1:0]      y_s [N+2][2];
	logic signed [Z_W-1:0]     z_s [N+1][2];
	logic                      fold_s [N+1][2];
	logic signed [COORD_W-1:0] rad_s [N+2];
	logic [N+1:0]              vld_s;
	logic [ANGLE_W-1:0]        fold_ang [2];
	logic                      fold_c [2];

	// fold into [-1/4, 1/4) turn when the top two bits differ
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			fold_c[l] = angle[l][ANGLE_W-1] ^ angle[l][ANGLE_W-2];
			fold_ang[l] = fold_c[l] ? (angle[l] ^ {1'b1, {(ANGLE_W-1){1'b0}}}) : angle[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[N:0], item_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s[0] <= radius;
			for (int s = 1; s < N + 2; s++) begin
				rad_s[s] <= rad_s[s-1];
			end
			for (int l = 0; l < 2; l++) begin
				x_s[0][l] <= K_START;
				y_s[0][l] <= '0;
				z_s[0][l] <= {{(Z_W-ANGLE_W){fold_ang[l][ANGLE_W-1]}}, fold_ang[l]};
				fold_s[0][l] <= fold_c[l];
				for (int s = 0; s < N; s++) begin
					fold_s[s+1][l] <= fold_s[s][l];
					if (!z_s[s][l][Z_W-1]) begin
						x_s[s+1][l] <= x_s[s][l] - (y_s[s][l] >>> s);
						y_s[s+1][l] <= y_s[s][l] + (x_s[s][l] >>> s);
						z_s[s+1][l] <= z_s[s][l] -
							signed'({{(Z_W-ANGLE_W){1'b0}}, ATAN_TURNS[s]});
					end else begin
						x_s[s+1][l] <= x_s[s][l] + (y_s[s][l] >>> s);
						y_s[s+1][l] <= y_s[s][l] - (x_s[s][l] >>> s);
						z_s[s+1][l] <= z_s[s][l] +
							signed'({{(Z_W-ANGLE_W){1'b0}}, ATAN_TURNS[s]});
					end
				end
				x_s[N+1][l] <= fold_s[N][l] ? -x_s[N][l] : x_s[N][l];
				y_s[N+1][l] <= fold_s[N][l] ? -y_s[N][l] : y_s[N][l];
			end
		end
	end

	assign res_valid = vld_s[N+1];
	assign radius_dly = rad_s[N+1];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			cosine[l] = x_s[N+1][l];
			sine[l] = y_s[N+1][l];
		end
	end

endmodule

### src/p2c_mulr.sv
// Four-stage multiply lanes: (a*b) >> FRAC rounded half away from zero, with a side tag.
module p2c_mulr #(
	parameter int LANES = 2,
	parameter int A_W = 32,
	parameter int B_W = 33,
	parameter int FRAC = 30,
	parameter int TAG_W = 1,
	parameter int R_W = 34
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    op_valid,
	input  logic signed [A_W-1:0]   op_a [LANES],
	input  logic signed [B_W-1:0]   op_b [LANES],
	input  logic [TAG_W-1:0]        op_tag,
	output logic                    prod_valid,
	output logic signed [R_W-1:0]   prod [LANES],
	output logic [TAG_W-1:0]        prod_tag
);
	localparam int LO_W = (B_W + 1) / 2;
	localparam int HI_W = B_W - LO_W;
	localparam int PP_W = A_W + B_W + 1;
	localparam logic [PP_W-1:0] RND = PP_W'(1) << (FRAC - 1);

	logic [A_W-1:0]         ua_s1 [LANES];
	logic [B_W-1:0]         ub_s1 [LANES];
	logic                   neg_s1 [LANES];
	logic [A_W+LO_W-1:0]    pl_s2 [LANES];
	logic [A_W+HI_W-1:0]    ph_s2 [LANES];
	logic                   neg_s2 [LANES];
	logic [R_W-1:0]         mag_s3 [LANES];
	logic                   neg_s3 [LANES];
	logic signed [R_W-1:0]  prod_s4 [LANES];
	logic [TAG_W-1:0]       tag_s1, tag_s2, tag_s3, tag_s4;
	logic                   vld_s1, vld_s2, vld_s3, vld_s4;
	logic [PP_W-1:0]        sum_c [LANES];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			sum_c[l] = (PP_W'(ph_s2[l]) << LO_W) + PP_W'(pl_s2[l]) + RND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= op_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1 <= op_tag;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			for (int l = 0; l < LANES; l++) begin
				ua_s1[l] <= op_a[l][A_W-1] ? A_W'(-op_a[l]) : A_W'(op_a[l]);
				ub_s1[l] <= op_b[l][B_W-1] ? B_W'(-op_b[l]) : B_W'(op_b[l]);
				neg_s1[l] <= op_a[l][A_W-1] ^ op_b[l][B_W-1];
				pl_s2[l] <= (A_W+LO_W)'(ua_s1[l]) * (A_W+LO_W)'(ub_s1[l][LO_W-1:0]);
				ph_s2[l] <= (A_W+HI_W)'(ua_s1[l]) * (A_W+HI_W)'(ub_s1[l][B_W-1:LO_W]);
				neg_s2[l] <= neg_s1[l];
				mag_s3[l] <= R_W'(sum_c[l] >> FRAC);
				neg_s3[l] <= neg_s2[l];
				prod_s4[l] <= neg_s3[l] ? -signed'(mag_s3[l]) : signed'(mag_s3[l]);
			end
		end
	end

	assign prod_valid = vld_s4;
	assign prod_tag = tag_s4;
	assign prod = prod_s4;

endmodule

### src/polar_to_cartesian_converter.sv
// Polar/spherical to Cartesian converter: CORDIC, two multiply ladders, saturating output.
// Pipeline from accepted point to coord_valid:
//   fold stage, one register per CORDIC rotation, sign restore, two 4-stage multiply ladders,
//   and the output register.
// Throughput: one point per cycle while point_stall is low; a skid register behind the output
//   holds one result, and the pipeline stalls (point_stall) while that skid register is occupied.
// Reset clears every valid bit and sets the mode register mode_q to 1 (spherical).
module polar_to_cartesian_converter #(
	parameter int CORDIC_STAGES = 24,
	parameter int DATA_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic                                cfg_wr_data,
	input  logic                                point_valid,
	output logic                                point_stall,
	input  logic signed [p2c_pkg::COORD_W-1:0] radius,
	input  logic [p2c_pkg::ANGLE_W-1:0]        azimuth_angle,
	input  logic [p2c_pkg::ANGLE_W-1:0]        polar_angle,
	output logic                                coord_valid,
	input  logic                                coord_stall,
	output logic signed [p2c_pkg::COORD_W-1:0] coord_x,
	output logic signed [p2c_pkg::COORD_W-1:0] coord_y,
	output logic signed [p2c_pkg::COORD_W-1:0] coord_z
);
	import p2c_pkg::*;

	localparam int CW = DATA_WIDTH + 1;
	localparam int F = DATA_WIDTH - 2;

	logic                      mode_q;
	logic                      en;
	logic                      skid_valid_q;
	logic                      out_valid_q;
	logic [COORD_W-1:0]        out_x_q, out_y_q, out_z_q;
	logic [COORD_W-1:0]        skid_x_q, skid_y_q, skid_z_q;

	logic [ANGLE_W-1:0]        angles [2];
	logic                      c_valid;
	logic signed [COORD_W-1:0] c_rad;
	logic signed [CW-1:0]      c_cos [2];
	logic signed [CW-1:0]      c_sin [2];

	logic signed [COORD_W-1:0] m1_a [3];
	logic signed [CW-1:0]      m1_b [3];
	logic                      m1_valid;
	logic signed [PROD1_W-1:0] m1_p [3];
	logic [CW-1:0]             m1_tag;

	logic signed [PROD1_W-1:0] m2_a [2];
	logic signed [CW-1:0]      m2_b [2];
	logic [3*PROD1_W-1:0]      m2_tag_in;
	logic [3*PROD1_W-1:0]      m2_tag;
	logic                      m2_valid;
	logic signed [PROD2_W-1:0] m2_p [2];

	logic signed [PROD1_W-1:0] px1, py1, pz1;
	logic signed [PROD2_W-1:0] fx, fy, fz;
	logic [COORD_W-1:0]        res_x, res_y, res_z;

	// pipeline freezes only while the skid register is occupied
	assign en = !skid_valid_q;
	assign point_stall = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	always_comb begin
		angles[0] = azimuth_angle;
		angles[1] = polar_angle;
	end

	p2c_cordic #(
		.CORDIC_STAGES(CORDIC_STAGES),
		.DATA_WIDTH   (DATA_WIDTH)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.item_valid(point_valid),
		.radius    (radius),
		.angle     (angles),
		.res_valid (c_valid),
		.radius_dly(c_rad),
		.cosine    (c_cos),
		.sine      (c_sin)
	);

	// r*cos(az), r*sin(az), r*cos(pol); sin(pol) rides along for the second ladder
	always_comb begin
		m1_a[0] = c_rad;
		m1_a[1] = c_rad;
		m1_a[2] = c_rad;
		m1_b[0] = c_cos[0];
		m1_b[1] = c_sin[0];
		m1_b[2] = c_cos[1];
	end

	p2c_mulr #(
		.LANES(3),
		.A_W  (COORD_W),
		.B_W  (CW),
		.FRAC (F),
		.TAG_W(CW),
		.R_W  (PROD1_W)
	) u_mul_rad (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.op_valid  (c_valid),
		.op_a      (m1_a),
		.op_b      (m1_b),
		.op_tag    (c_sin[1]),
		.prod_valid(m1_valid),
		.prod      (m1_p),
		.prod_tag  (m1_tag)
	);

	always_comb begin
		m2_a[0] = m1_p[0];
		m2_a[1] = m1_p[1];
		m2_b[0] = signed'(m1_tag);
		m2_b[1] = signed'(m1_tag);
		m2_tag_in = {m1_p[0], m1_p[1], m1_p[2]};
	end

	p2c_mulr #(
		.LANES(2),
		.A_W  (PROD1_W),
		.B_W  (CW),
		.FRAC (F),
		.TAG_W(3 * PROD1_W),
		.R_W  (PROD2_W)
	) u_mul_pol (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.op_valid  (m1_valid),
		.op_a      (m2_a),
		.op_b      (m2_b),
		.op_tag    (m2_tag_in),
		.prod_valid(m2_valid),
		.prod      (m2_p),
		.prod_tag  (m2_tag)
	);

	always_comb begin
		px1 = signed'(m2_tag[3*PROD1_W-1:2*PROD1_W]);
		py1 = signed'(m2_tag[2*PROD1_W-1:PROD1_W]);
		pz1 = signed'(m2_tag[PROD1_W-1:0]);
		if (mode_q) begin
			fx = m2_p[0];
			fy = m2_p[1];
			fz = PROD2_W'(pz1);
		end else begin
			fx = PROD2_W'(px1);
			fy = PROD2_W'(py1);
			fz = '0;
		end
		res_x = sat_coord(fx);
		res_y = sat_coord(fy);
		res_z = sat_coord(fz);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (!coord_stall) begin
				skid_valid_q <= 1'b0;
			end
		end else if (m2_valid) begin
			if (out_valid_q && coord_stall) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (!coord_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && m2_valid) begin
			skid_x_q <= res_x;
			skid_y_q <= res_y;
			skid_z_q <= res_z;
		end
		if (skid_valid_q) begin
			if (!coord_stall) begin
				out_x_q <= skid_x_q;
				out_y_q <= skid_y_q;
				out_z_q <= skid_z_q;
			end
		end else if (m2_valid && (!out_valid_q || !coord_stall)) begin
			out_x_q <= res_x;
			out_y_q <= res_y;
			out_z_q <= res_z;
		end
	end

	assign coord_valid = out_valid_q;
	assign coord_x = signed'(out_x_q);
	assign coord_y = signed'(out_y_q);
	assign coord_z = signed'(out_z_q);

	// skid fills only when a finished result meets a stalled, occupied output
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && coord_stall && m2_valid))
		else $error("skid register filled without a stalled output transaction");

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds data while output register is empty");

	a_pipe_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |=> $stable(m2_valid) && $stable(m2_p[0]) && $stable(m2_tag))
		else $error("pipeline tail moved while skid register was occupied");

endmodule
